/* rtl/core/q2rm_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the quaternion to rotation matrix pipeline
// no dependencies
package q2rm_pkg;

	localparam int COMP_W    = 16;              // input component, q3.12
	localparam int ENTRY_W   = 16;              // matrix entry, q1.14
	localparam int LANES     = 9;               // matrix entries per word
	localparam int QUO_W     = 15;              // unsigned quotient bits
	localparam int DIV_STEPS = QUO_W;           // one quotient bit per stage
	localparam int QUAD_W    = 33;              // quadrance, up to 2^32
	localparam int NUM_W     = 34;              // signed numerator, |num| <= 2^32
	localparam int DEN_W     = QUAD_W + 1;      // twice the quadrance
	localparam int DIVD_W    = QUAD_W + QUO_W;  // (mag << 15) + quadrance

	localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

	// lanes that carry a diagonal entry, identity on a zero quaternion
	localparam logic [LANES-1:0] DIAG_MASK = 9'b100010001;

	typedef struct packed {
		logic signed [COMP_W-1:0] comp_w;
		logic signed [COMP_W-1:0] comp_x;
		logic signed [COMP_W-1:0] comp_y;
		logic signed [COMP_W-1:0] comp_z;
	} quat_t;

	typedef struct packed {
		logic signed [ENTRY_W-1:0] r0c0;
		logic signed [ENTRY_W-1:0] r0c1;
		logic signed [ENTRY_W-1:0] r0c2;
		logic signed [ENTRY_W-1:0] r1c0;
		logic signed [ENTRY_W-1:0] r1c1;
		logic signed [ENTRY_W-1:0] r1c2;
		logic signed [ENTRY_W-1:0] r2c0;
		logic signed [ENTRY_W-1:0] r2c1;
		logic signed [ENTRY_W-1:0] r2c2;
		logic                      degenerate;
	} rot_t;

	// one lane of the restoring divider
	typedef struct packed {
		logic [DEN_W-1:0] rem;    // partial remainder, always below den
		logic [QUO_W-1:0] nbits;  // dividend bits not yet shifted in
		logic [QUO_W-1:0] quo;    // quotient bits so far
		logic             neg;    // sign of the entry
	} div_lane_t;

	typedef struct packed {
		div_lane_t [LANES-1:0] lane;
		logic [DEN_W-1:0]      den;
		logic                  degen;
	} div_word_t;

endpackage

/* rtl/core/q2rm_stream_if.sv */
`timescale 1ns / 1ps
// valid/ready stream channel carrying one word of any packed type
// no dependencies
interface q2rm_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/q2rm_div_step.sv */
`timescale 1ns / 1ps
// one restoring division step for all nine lanes, with its pipeline register
// depends on q2rm_pkg
module q2rm_div_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  q2rm_pkg::div_word_t  in_word,
	output logic                 out_valid,
	output q2rm_pkg::div_word_t  out_word
);
	import q2rm_pkg::*;

	div_word_t nxt;
	div_word_t word_s1;
	logic      valid_s1;

	always_comb begin
		logic [DEN_W:0] part;
		logic [DEN_W:0] diff;
		nxt = in_word;
		for (int i = 0; i < LANES; i++) begin
			part = {in_word.lane[i].rem, in_word.lane[i].nbits[QUO_W-1]};
			diff = part - {1'b0, in_word.den};
			nxt.lane[i].nbits = {in_word.lane[i].nbits[QUO_W-2:0], 1'b0};
			if (part >= {1'b0, in_word.den}) begin
				nxt.lane[i].rem = diff[DEN_W-1:0];
				nxt.lane[i].quo = {in_word.lane[i].quo[QUO_W-2:0], 1'b1};
			end else begin
				nxt.lane[i].rem = part[DEN_W-1:0];
				nxt.lane[i].quo = {in_word.lane[i].quo[QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;
endmodule

/* rtl/core/quaternion_to_rotation_matrix.sv */
`timescale 1ns / 1ps
// Converts a quaternion (w,x,y,z) in signed q3.12 into the nine entries of its
// 3x3 rotation matrix in signed q1.14, scaled by the quadrance so the input need
// not be unit length. Each entry is round(num * 16384 / (ww+xx+yy+zz)), rounded
// to nearest with ties away from zero and clamped to +-1.0. An all-zero
// quaternion gives the identity matrix with the degenerate flag set. The block
// takes one word per cycle unless the output stalls, through one stage of ten
// 16x16 products, one stage of sums, one stage of sign and magnitude, fifteen
// restoring divide stages (one quotient bit each, nine lanes in parallel) and
// the output register. Every stage stalls on its own, so bubbles are squeezed
// out and input words keep coming while a result waits at the output.
// depends on q2rm_pkg, q2rm_stream_if, q2rm_div_step
module quaternion_to_rotation_matrix (
	input  logic                   clk,
	input  logic                   arst_n,
	q2rm_stream_if.sink            quat,
	q2rm_stream_if.source          rot
);
	import q2rm_pkg::*;

	localparam int SUM_W = NUM_W + 1;

	function automatic logic signed [SUM_W-1:0] sx(input logic signed [2*COMP_W-1:0] v);
		sx = {{(SUM_W - 2*COMP_W){v[2*COMP_W-1]}}, v};
	endfunction

	// stage enables, each stage moves when it is empty or its successor moves
	logic              en_s1, en_s2, en_s3, en_out;
	logic [DIV_STEPS:1] div_en;

	// stage 1: products
	logic                             v_s1;
	logic signed [2*COMP_W-1:0]       ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [2*COMP_W-1:0]       xy_s1, xz_s1, yz_s1, xw_s1, yw_s1, zw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= quat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ww_s1 <= quat.data.comp_w * quat.data.comp_w;
			xx_s1 <= quat.data.comp_x * quat.data.comp_x;
			yy_s1 <= quat.data.comp_y * quat.data.comp_y;
			zz_s1 <= quat.data.comp_z * quat.data.comp_z;
			xy_s1 <= quat.data.comp_x * quat.data.comp_y;
			xz_s1 <= quat.data.comp_x * quat.data.comp_z;
			yz_s1 <= quat.data.comp_y * quat.data.comp_z;
			xw_s1 <= quat.data.comp_x * quat.data.comp_w;
			yw_s1 <= quat.data.comp_y * quat.data.comp_w;
			zw_s1 <= quat.data.comp_z * quat.data.comp_w;
		end
	end

	// stage 2: quadrance and the nine numerators
	logic signed [SUM_W-1:0] qs;
	logic signed [SUM_W-1:0] num [LANES];

	always_comb begin
		qs = sx(ww_s1) + sx(xx_s1) + sx(yy_s1) + sx(zz_s1);
		// diagonal entries use q - 2(..), off-diagonal ones 2(..)
		num[0] = qs - ((sx(yy_s1) + sx(zz_s1)) <<< 1);
		num[1] = (sx(xy_s1) + sx(zw_s1)) <<< 1;
		num[2] = (sx(xz_s1) - sx(yw_s1)) <<< 1;
		num[3] = (sx(xy_s1) - sx(zw_s1)) <<< 1;
		num[4] = qs - ((sx(xx_s1) + sx(zz_s1)) <<< 1);
		num[5] = (sx(yz_s1) + sx(xw_s1)) <<< 1;
		num[6] = (sx(xz_s1) + sx(yw_s1)) <<< 1;
		num[7] = (sx(yz_s1) - sx(xw_s1)) <<< 1;
		num[8] = qs - ((sx(xx_s1) + sx(yy_s1)) <<< 1);
	end

	logic                    v_s2;
	logic [QUAD_W-1:0]       quad_s2;
	logic                    degen_s2;
	logic signed [NUM_W-1:0] num_s2 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			quad_s2  <= qs[QUAD_W-1:0];
			degen_s2 <= (qs == '0);
			for (int i = 0; i < LANES; i++) begin
				num_s2[i] <= num[i][NUM_W-1:0];
			end
		end
	end

	// stage 3: sign, magnitude, rounded dividend (mag << 15) + q over 2q
	div_word_t setup;

	always_comb begin
		logic [NUM_W-1:0]  mag;
		logic [DIVD_W-1:0] divd;
		setup.den   = {quad_s2, 1'b0};
		setup.degen = degen_s2;
		for (int i = 0; i < LANES; i++) begin
			mag = num_s2[i][NUM_W-1] ? (NUM_W'(0) - num_s2[i]) : num_s2[i];
			divd = {mag[QUAD_W-1:0], {QUO_W{1'b0}}} + {{QUO_W{1'b0}}, quad_s2};
			// top part is known to be below the divisor, so no quotient bit is lost
			setup.lane[i].rem   = {1'b0, divd[DIVD_W-1:QUO_W]};
			setup.lane[i].nbits = divd[QUO_W-1:0];
			setup.lane[i].quo   = '0;
			setup.lane[i].neg   = num_s2[i][NUM_W-1];
		end
	end

	logic      v_s3;
	div_word_t word_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			word_s3 <= setup;
		end
	end

	// divide stages, one quotient bit each
	logic [DIV_STEPS:0] div_v;
	div_word_t          div_w [DIV_STEPS+1];

	assign div_v[0] = v_s3;
	assign div_w[0] = word_s3;

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		q2rm_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (div_en[k]),
			.in_valid  (div_v[k-1]),
			.in_word   (div_w[k-1]),
			.out_valid (div_v[k]),
			.out_word  (div_w[k])
		);
		if (k < DIV_STEPS) begin : g_mid
			assign div_en[k] = !div_v[k] || div_en[k+1];
		end else begin : g_last
			assign div_en[k] = !div_v[k] || en_out;
		end
	end

	assign en_s3 = !v_s3 || div_en[1];
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign quat.ready = en_s1;

	// final: clamp, apply sign, identity on a zero quaternion
	logic signed [ENTRY_W-1:0] entry [LANES];
	rot_t                      res;

	always_comb begin
		logic [QUO_W-1:0]   mag;
		logic [ENTRY_W-1:0] ext;
		for (int i = 0; i < LANES; i++) begin
			mag = (div_w[DIV_STEPS].lane[i].quo > ONE_Q14) ? ONE_Q14
				: div_w[DIV_STEPS].lane[i].quo;
			ext = {1'b0, mag};
			if (div_w[DIV_STEPS].degen) begin
				entry[i] = DIAG_MASK[i] ? {1'b0, ONE_Q14} : '0;
			end else begin
				entry[i] = div_w[DIV_STEPS].lane[i].neg ? (ENTRY_W'(0) - ext) : ext;
			end
		end
		res.r0c0       = entry[0];
		res.r0c1       = entry[1];
		res.r0c2       = entry[2];
		res.r1c0       = entry[3];
		res.r1c1       = entry[4];
		res.r1c2       = entry[5];
		res.r2c0       = entry[6];
		res.r2c1       = entry[7];
		res.r2c2       = entry[8];
		res.degenerate = div_w[DIV_STEPS].degen;
	end

	// output register, holds a word until the sink takes it
	logic out_v_q;
	rot_t out_q;

	assign en_out = !out_v_q || rot.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= div_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q <= res;
		end
	end

	assign rot.valid = out_v_q;
	assign rot.data  = out_q;
endmodule
